@@ hdl/erv_pkg.sv @@
// Shared types, constants and step tables for the Euler vertex rotator.
package erv_pkg;

  localparam int ANGLE_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int DIVD_W      = 31;
  localparam int DIVR_W      = 14;
  localparam int Q_W         = 32;
  localparam int MAG_W       = 31;
  localparam int MSTEPS      = 14;

  localparam int UNITS_TURN      = 23040;
  localparam int UNITS_HALF_TURN = 11520;
  localparam int UNITS_QUARTER   = 5760;
  localparam int UNITS_OCTANT    = 2880;

  localparam logic [63:0] PI_Q48 = 64'h3243F6A8885A3;
  localparam logic [63:0] T_QUO  = PI_Q48 / 64'd11520;
  localparam logic [63:0] T_REM  = PI_Q48 % 64'd11520;

  localparam logic signed [Q_W-1:0] Q30_ONE = 32'sh4000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic busy;
  } mat_status_t;

  typedef enum logic [2:0] {
    SEL_SX, SEL_CX, SEL_SY, SEL_CY, SEL_SZ, SEL_CZ, SEL_SXSY, SEL_CXSY
  } msel_t;

  typedef enum logic [2:0] {
    MOP_SXSY, MOP_CXSY, MOP_LOAD, MOP_LOADN, MOP_EMIT, MOP_EMIT_ACC
  } mop_t;

  typedef struct packed {
    msel_t      a;
    msel_t      b;
    mop_t       op;
    logic [3:0] dest;
  } mstep_t;

  // Products for R = Rz * Ry * Rx; element 6 is taken from -sin(y) directly.
  function automatic mstep_t mstep(input logic [3:0] i);
    mstep_t s;
    case (i)
      4'd0:    s = '{SEL_SX,   SEL_SY, MOP_SXSY,     4'd0};
      4'd1:    s = '{SEL_CX,   SEL_SY, MOP_CXSY,     4'd0};
      4'd2:    s = '{SEL_CY,   SEL_CZ, MOP_EMIT,     4'd0};
      4'd3:    s = '{SEL_CX,   SEL_SZ, MOP_LOADN,    4'd0};
      4'd4:    s = '{SEL_SXSY, SEL_CZ, MOP_EMIT_ACC, 4'd1};
      4'd5:    s = '{SEL_SX,   SEL_SZ, MOP_LOAD,     4'd0};
      4'd6:    s = '{SEL_CXSY, SEL_CZ, MOP_EMIT_ACC, 4'd2};
      4'd7:    s = '{SEL_CY,   SEL_SZ, MOP_EMIT,     4'd3};
      4'd8:    s = '{SEL_CX,   SEL_CZ, MOP_LOAD,     4'd0};
      4'd9:    s = '{SEL_SXSY, SEL_SZ, MOP_EMIT_ACC, 4'd4};
      4'd10:   s = '{SEL_SX,   SEL_CZ, MOP_LOADN,    4'd0};
      4'd11:   s = '{SEL_CXSY, SEL_SZ, MOP_EMIT_ACC, 4'd5};
      4'd12:   s = '{SEL_SX,   SEL_CY, MOP_EMIT,     4'd7};
      4'd13:   s = '{SEL_CX,   SEL_CY, MOP_EMIT,     4'd8};
      default: s = '{SEL_SX,   SEL_SX, MOP_LOAD,     4'd0};
    endcase
    return s;
  endfunction

  // Taylor term divisors n*(n+1): sine uses even n, cosine odd.
  function automatic logic [DIVR_W-1:0] series_divisor(input logic cos_phase,
                                                        input logic [2:0] k);
    logic [DIVR_W-1:0] d;
    case ({cos_phase, k})
      4'b0_001: d = 14'd6;
      4'b0_010: d = 14'd20;
      4'b0_011: d = 14'd42;
      4'b0_100: d = 14'd72;
      4'b1_001: d = 14'd2;
      4'b1_010: d = 14'd12;
      4'b1_011: d = 14'd30;
      4'b1_100: d = 14'd56;
      4'b1_101: d = 14'd90;
      default:  d = 14'd1;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/erv_div.sv @@
// Divider for the fixed set of series and angle divisors, by reciprocal multiplication.
module erv_div
  import erv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int PW = DIVD_W + 32;

  logic [DIVD_W-1:0] dvd_r;
  logic [31:0]       rcp_r;
  logic [5:0]        sh_r;
  logic [PW-1:0]     prod_r;
  logic [5:0]        psh_r;
  logic              s1_r;
  logic              s2_r;
  logic              done_r;
  logic [DIVD_W-1:0] quo_r;
  logic [31:0]       rcp;
  logic [5:0]        sh;

  // Each divisor d maps to ceil(2^sh / d) with sh = DIVD_W + ceil(log2 d), which is exact
  // for every dividend of DIVD_W bits.
  always_comb begin
    case (req.divisor)
      14'd2: begin
        rcp = 32'd2147483648;
        sh  = 6'd32;
      end
      14'd6: begin
        rcp = 32'd2863311531;
        sh  = 6'd34;
      end
      14'd12: begin
        rcp = 32'd2863311531;
        sh  = 6'd35;
      end
      14'd20: begin
        rcp = 32'd3435973837;
        sh  = 6'd36;
      end
      14'd30: begin
        rcp = 32'd2290649225;
        sh  = 6'd36;
      end
      14'd42: begin
        rcp = 32'd3272356036;
        sh  = 6'd37;
      end
      14'd56: begin
        rcp = 32'd2454267027;
        sh  = 6'd37;
      end
      14'd72: begin
        rcp = 32'd3817748708;
        sh  = 6'd38;
      end
      14'd90: begin
        rcp = 32'd3054198967;
        sh  = 6'd38;
      end
      DIVR_W'(UNITS_HALF_TURN): begin
        rcp = 32'd3054198967;
        sh  = 6'd45;
      end
      default: begin
        rcp = 32'd2147483648;
        sh  = 6'd31;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= req.start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
    if (req.start) begin
      dvd_r <= req.dividend;
      rcp_r <= rcp;
      sh_r  <= sh;
    end
    if (s1_r) begin
      prod_r <= PW'(dvd_r) * PW'(rcp_r);
      psh_r  <= sh_r;
    end
    if (s2_r) begin
      quo_r <= DIVD_W'(prod_r >> psh_r);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hdl/erv_mat.sv @@
// Angle registers, sine/cosine series sequencer and rotation matrix store.
module erv_mat
  import erv_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [CFG_INDEX_W-1:0]         wr_index,
  input  logic [ANGLE_W-1:0]             wr_data,
  output mat_status_t                    status,
  output logic signed [COEF_FRAC_BITS+1:0] coef [9]
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int SH = 30 - COEF_FRAC_BITS;
  localparam logic [33:0] C_ONE  = 34'(1) << COEF_FRAC_BITS;
  localparam logic [33:0] C_HALF = 34'(1) << (SH - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_FOLD  = 11'b000_0000_0010,
    S_TDIV  = 11'b000_0000_0100,
    S_T2A   = 11'b000_0000_1000,
    S_T2B   = 11'b000_0001_0000,
    S_SMUL  = 11'b000_0010_0000,
    S_SDIVS = 11'b000_0100_0000,
    S_SDIV  = 11'b000_1000_0000,
    S_STORE = 11'b001_0000_0000,
    S_MMUL  = 11'b010_0000_0000,
    S_MACC  = 11'b100_0000_0000
  } state_t;

  function automatic logic signed [CW-1:0] to_coef(input logic signed [32:0] v);
    logic        neg;
    logic [33:0] u;
    logic [33:0] m;
    neg = v[32];
    u   = neg ? 34'(-34'(v)) : 34'(v);
    m   = (u + C_HALF) >> SH;
    if (m > C_ONE) m = C_ONE;
    return neg ? CW'(34'(0) - m) : CW'(m);
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  state_t state_r, state_nxt;

  logic [ANGLE_W-1:0]        angle_r [3];
  logic [1:0]                axis_r;
  logic signed [Q_W-1:0]     sin_r [3];
  logic signed [Q_W-1:0]     cos_r [3];
  logic signed [Q_W-1:0]     sxsy_r, cxsy_r;
  logic signed [32:0]        acc_r;
  logic signed [CW-1:0]      mat_r [9];

  logic [11:0]               rf_r;
  logic [1:0]                quad_r;
  logic                      swap_r;
  logic [MAG_W-1:0]          t_r, t2_r, term_r;
  logic signed [Q_W-1:0]     sum_r, sin0_r;
  logic [2:0]                k_r;
  logic                      cphase_r;
  logic [3:0]                step_r;

  logic [MAG_W-1:0]          mul_a, mul_b;
  logic                      mul_neg;
  logic [2*MAG_W-1:0]        prod_r;
  logic                      neg_r;

  div_req_t                  dreq;
  div_rsp_t                  drsp;

  logic                      wr_ok;
  logic [ANGLE_W-1:0]        ang;
  logic signed [16:0]        w;
  logic [14:0]               u;
  logic [1:0]                q;
  logic [12:0]               rr;
  logic [11:0]               rf;
  logic                      sw;
  logic [48:0]               tsum;
  mstep_t                    ms;
  logic signed [Q_W-1:0]     opa, opb;
  logic [Q_W-1:0]            pmag;
  logic signed [32:0]        p;
  logic [MAG_W-1:0]          dq;
  logic signed [Q_W-1:0]     sum_new;
  logic signed [Q_W-1:0]     s0, c0, sq, cq;

  function automatic logic signed [Q_W-1:0] pick(input msel_t s,
      input logic signed [Q_W-1:0] sx, input logic signed [Q_W-1:0] cx,
      input logic signed [Q_W-1:0] sy, input logic signed [Q_W-1:0] cy,
      input logic signed [Q_W-1:0] sz, input logic signed [Q_W-1:0] cz,
      input logic signed [Q_W-1:0] a,  input logic signed [Q_W-1:0] b);
    logic signed [Q_W-1:0] r;
    case (s)
      SEL_SX:   r = sx;
      SEL_CX:   r = cx;
      SEL_SY:   r = sy;
      SEL_CY:   r = cy;
      SEL_SZ:   r = sz;
      SEL_CZ:   r = cz;
      SEL_SXSY: r = a;
      SEL_CXSY: r = b;
      default:  r = sx;
    endcase
    return r;
  endfunction

  assign wr_ok = wr_en && (wr_index == REG_ANGLE_X || wr_index == REG_ANGLE_Y ||
                           wr_index == REG_ANGLE_Z);

  // Fold the angle to one turn, then to a quadrant and an octant.
  always_comb begin
    ang = angle_r[axis_r];
    w   = 17'(signed'(ang));
    if (w < 0) w = w + 17'(UNITS_TURN);
    if (w < 0) w = w + 17'(UNITS_TURN);
    if (w >= 17'(UNITS_TURN)) w = w - 17'(UNITS_TURN);
    u = w[14:0];
    if (u >= 15'(3 * UNITS_QUARTER)) begin
      q  = 2'd3;
      rr = 13'(u - 15'(3 * UNITS_QUARTER));
    end else if (u >= 15'(UNITS_HALF_TURN)) begin
      q  = 2'd2;
      rr = 13'(u - 15'(UNITS_HALF_TURN));
    end else if (u >= 15'(UNITS_QUARTER)) begin
      q  = 2'd1;
      rr = 13'(u - 15'(UNITS_QUARTER));
    end else begin
      q  = 2'd0;
      rr = 13'(u);
    end
    if (rr > 13'(UNITS_OCTANT)) begin
      sw = 1'b1;
      rf = 12'(13'(UNITS_QUARTER) - rr);
    end else begin
      sw = 1'b0;
      rf = rr[11:0];
    end
  end

  assign tsum = 49'(48'(rf_r) * T_QUO[47:0]) + 49'(drsp.quotient) + 49'(1 << 17);

  assign ms  = mstep(step_r);
  assign opa = pick(ms.a, sin_r[0], cos_r[0], sin_r[1], cos_r[1], sin_r[2], cos_r[2],
                    sxsy_r, cxsy_r);
  assign opb = pick(ms.b, sin_r[0], cos_r[0], sin_r[1], cos_r[1], sin_r[2], cos_r[2],
                    sxsy_r, cxsy_r);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_r)
      S_T2A: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      S_SMUL: begin
        mul_a = term_r;
        mul_b = t2_r;
      end
      S_MMUL: begin
        mul_a   = mag(opa);
        mul_b   = mag(opb);
        mul_neg = opa[Q_W-1] ^ opb[Q_W-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign pmag = Q_W'((prod_r + 62'(1 << 29)) >> 30);
  assign p    = neg_r ? -33'(pmag) : 33'(pmag);
  assign dq   = drsp.quotient[MAG_W-1:0];
  assign sum_new = k_r[0] ? sum_r - Q_W'(dq) : sum_r + Q_W'(dq);

  always_comb begin
    s0 = swap_r ? sum_r : sin0_r;
    c0 = swap_r ? sin0_r : sum_r;
    case (quad_r)
      2'd0:    begin sq = s0;  cq = c0;  end
      2'd1:    begin sq = c0;  cq = -s0; end
      2'd2:    begin sq = -s0; cq = -c0; end
      default: begin sq = -c0; cq = s0;  end
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    case (state_r)
      S_FOLD: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(26'(rf) * 26'(T_REM[DIVR_W-1:0]));
        dreq.divisor  = DIVR_W'(UNITS_HALF_TURN);
      end
      S_SDIVS: begin
        dreq.start    = 1'b1;
        dreq.dividend = prod_r[60:30];
        dreq.divisor  = series_divisor(cphase_r, k_r);
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  erv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (wr_ok) state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_TDIV;
      S_TDIV:  if (drsp.done) state_nxt = S_T2A;
      S_T2A:   state_nxt = S_T2B;
      S_T2B:   state_nxt = S_SMUL;
      S_SMUL:  state_nxt = S_SDIVS;
      S_SDIVS: state_nxt = S_SDIV;
      S_SDIV: begin
        if (drsp.done) begin
          if (cphase_r && k_r == 3'd5) state_nxt = S_STORE;
          else state_nxt = S_SMUL;
        end
      end
      S_STORE: state_nxt = S_MMUL;
      S_MMUL:  state_nxt = S_MACC;
      S_MACC:  state_nxt = (step_r == 4'(MSTEPS - 1)) ? S_IDLE : S_MMUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    neg_r  <= mul_neg;
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        angle_r[i] <= '0;
        sin_r[i]   <= '0;
        cos_r[i]   <= Q30_ONE;
      end
      for (int i = 0; i < 9; i++) begin
        mat_r[i] <= (i % 4 == 0) ? CW'(C_ONE) : '0;
      end
      axis_r <= '0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (wr_ok) begin
            angle_r[wr_index] <= wr_data;
            axis_r            <= wr_index;
          end
        end
        S_FOLD: begin
          rf_r   <= rf;
          quad_r <= q;
          swap_r <= sw;
        end
        S_TDIV: begin
          if (drsp.done) t_r <= tsum[48:18];
        end
        S_T2B: begin
          t2_r     <= prod_r[60:30];
          term_r   <= t_r;
          sum_r    <= Q_W'(t_r);
          k_r      <= 3'd1;
          cphase_r <= 1'b0;
        end
        S_SDIV: begin
          if (drsp.done) begin
            if (!cphase_r && k_r == 3'd4) begin
              sin0_r   <= sum_new;
              term_r   <= MAG_W'(Q30_ONE);
              sum_r    <= Q30_ONE;
              k_r      <= 3'd1;
              cphase_r <= 1'b1;
            end else begin
              term_r <= dq;
              sum_r  <= sum_new;
              k_r    <= k_r + 3'd1;
            end
          end
        end
        S_STORE: begin
          sin_r[axis_r] <= sq;
          cos_r[axis_r] <= cq;
          step_r        <= '0;
        end
        S_MACC: begin
          case (ms.op)
            MOP_SXSY:     sxsy_r <= Q_W'(p);
            MOP_CXSY:     cxsy_r <= Q_W'(p);
            MOP_LOAD:     acc_r  <= p;
            MOP_LOADN:    acc_r  <= -p;
            MOP_EMIT:     mat_r[ms.dest] <= to_coef(p);
            MOP_EMIT_ACC: mat_r[ms.dest] <= to_coef(acc_r + p);
            default:      acc_r  <= acc_r;
          endcase
          if (step_r == 4'(MSTEPS - 1)) begin
            mat_r[6] <= to_coef(-33'(sin_r[1]));
          end
          step_r <= step_r + 4'd1;
        end
        default: begin
          step_r <= step_r;
        end
      endcase
    end
  end

  assign status.busy = (state_r != S_IDLE);
  assign coef = mat_r;

endmodule

@@ hdl/erv_xform.sv @@
// Three-stage vertex datapath: input register, nine products, sum with rounding.
module erv_xform
  import erv_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            hold,
  input  logic signed [COEF_FRAC_BITS+1:0] coef [9],
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_x,
  input  logic signed [COORD_WIDTH-1:0]   in_y,
  input  logic signed [COORD_WIDTH-1:0]   in_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [COORD_WIDTH-1:0]   out_x,
  output logic signed [COORD_WIDTH-1:0]   out_y,
  output logic signed [COORD_WIDTH-1:0]   out_z
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + CW;
  localparam int SW = PW + 2;
  localparam int RW = SW - COEF_FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] MAXV =
    {{(RW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = ~MAXV;

  logic                          v0_valid_r, v1_valid_r, out_valid_r;
  logic signed [COORD_WIDTH-1:0] v0_r [3];
  logic signed [PW-1:0]          prod_r [9];
  logic signed [COORD_WIDTH-1:0] out_r [3];
  logic                          out_ready, s1_ready, s0_ready;
  logic signed [SW-1:0]          sum [3];
  logic signed [RW-1:0]          shr [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !v1_valid_r || out_ready;
  assign s0_ready  = !v0_valid_r || s1_ready;
  assign in_stall  = hold || !s0_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(prod_r[i*3]) + SW'(prod_r[i*3+1]) + SW'(prod_r[i*3+2]) + HALF;
      shr[i] = RW'(sum[i] >>> COEF_FRAC_BITS);
      if (shr[i] > MAXV) sat[i] = MAXV[COORD_WIDTH-1:0];
      else if (shr[i] < MINV) sat[i] = MINV[COORD_WIDTH-1:0];
      else sat[i] = shr[i][COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_valid_r  <= 1'b0;
      v1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_ready) v0_valid_r <= in_valid && !hold;
      if (s1_ready) v1_valid_r <= v0_valid_r;
      if (out_ready) out_valid_r <= v1_valid_r;
    end
    if (s0_ready && in_valid && !hold) begin
      v0_r[0] <= in_x;
      v0_r[1] <= in_y;
      v0_r[2] <= in_z;
    end
    if (s1_ready && v0_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i*3+j] <= PW'(coef[i*3+j] * v0_r[j]);
        end
      end
    end
    if (out_ready && v1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        out_r[i] <= sat[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];

endmodule

@@ hdl/euler_rotate_vertex_3d.sv @@
// Top level of the Euler vertex rotator: configuration port, matrix unit and datapath.
// Rotates one Q16.16 vertex per cycle by R = Rz*Ry*Rx while the output is not stalled and
// no rebuild or configuration write holds the input; a word passes the input, product and
// output registers in turn. Writing an angle register rebuilds the matrix in a sequencer
// that shares one 31x31 multiplier and a reciprocal-multiply divider; a rebuild converts
// the angle, runs the sine and cosine series (ten divisions in all), stores them and forms
// the matrix products; the input channel and configuration port stall until it ends.
module euler_rotate_vertex_3d
  import erv_pkg::*;
#(
  parameter int COORD_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ANGLE_W-1:0]            cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z
);

  mat_status_t                      mstat;
  logic signed [COEF_FRAC_BITS+1:0] coef [9];
  logic                             cfg_wr;

  assign cfg_ready = !mstat.busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  erv_mat #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .status   (mstat),
    .coef     (coef)
  );

  erv_xform #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (mstat.busy || cfg_valid),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

`ifndef SYNTH
  a_rebuild_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
               cfg_index == REG_ANGLE_Z) |=> mstat.busy)
    else $error("Angle write did not start a matrix rebuild.");
  a_no_word_during_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.busy |-> in_stall)
    else $error("Input word could be taken while the matrix is rebuilt.");
`endif

endmodule
